@@ hdl/wim_pkg.sv @@
// ----------------------------------------------------------------------------
// wim_pkg: shared types and codes of the wide integer multiply / divide unit
// Operation codes, status codes and the record that moves down the cell row.
// ----------------------------------------------------------------------------
package wim_pkg;

    localparam int W = 128;

    localparam logic [3:0] K_SMUL_WRAP = 4'd0;
    localparam logic [3:0] K_SMUL_TRAP = 4'd1;
    localparam logic [3:0] K_UMUL_WRAP = 4'd2;
    localparam logic [3:0] K_UMUL_TRAP = 4'd3;
    localparam logic [3:0] K_SDIV_WRAP = 4'd4;
    localparam logic [3:0] K_SDIV_TRAP = 4'd5;
    localparam logic [3:0] K_UDIV      = 4'd6;
    localparam logic [3:0] K_SMOD_WRAP = 4'd7;
    localparam logic [3:0] K_SMOD_TRAP = 4'd8;
    localparam logic [3:0] K_UMOD      = 4'd9;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [3:0]       kind;
        logic             is_mul;
        logic             is_div;
        logic             neg_q;
        logic             neg_r;
        logic             dz;
        logic             ovf;
        logic [2*W-1:0]   acc;
        logic [2*W-1:0]   opx;
        logic [W-1:0]     opy;
    } cell_t;

endpackage

@@ hdl/wim_cell.sv @@
// ----------------------------------------------------------------------------
// wim_cell: one step of the multiply / divide row
// Adds one shifted multiplicand or performs one restoring division step.
// ----------------------------------------------------------------------------
module wim_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  wim_pkg::cell_t d_in,
    output wim_pkg::cell_t d_out
);
    import wim_pkg::*;

    cell_t          cell_next;
    cell_t          data_reg;
    logic           valid_reg;
    logic [W:0]     rem_sh;
    logic [W:0]     rem_diff;
    logic           ge;

    always_comb
    begin
        cell_next = d_in;
        rem_sh    = {d_in.acc[W-1:0], d_in.acc[2*W-1]};
        rem_diff  = rem_sh - {1'b0, d_in.opx[W-1:0]};
        ge        = (rem_sh >= {1'b0, d_in.opx[W-1:0]});
        if (d_in.is_mul)
        begin
            if (d_in.opy[0])
            begin
                cell_next.acc = d_in.acc + d_in.opx;
            end
            cell_next.opx = {d_in.opx[2*W-2:0], 1'b0};
            cell_next.opy = {1'b0, d_in.opy[W-1:1]};
        end
        else if (d_in.is_div)
        begin
            cell_next.acc = {d_in.acc[2*W-2:W], 1'b0,
                             (ge ? rem_diff[W-1:0] : rem_sh[W-1:0])};
            cell_next.opy = {d_in.opy[W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= cell_next;
        end
    end

    always_comb
    begin
        d_out       = data_reg;
        d_out.valid = valid_reg;
    end

endmodule

@@ hdl/wim_post.sv @@
// ----------------------------------------------------------------------------
// wim_post: result fix-up at the end of the cell row
// Applies signs, detects multiply overflow and forces trapped results to zero.
// ----------------------------------------------------------------------------
module wim_post (
    input  wim_pkg::cell_t   c,
    output logic [127:0]     res,
    output logic [1:0]       st
);
    import wim_pkg::*;

    logic [W-1:0] low;
    logic [W-1:0] low_n;
    logic [W-1:0] q_n;
    logic [W-1:0] r_n;
    logic         upper;
    logic         exact_min;

    always_comb
    begin
        low       = c.acc[W-1:0];
        low_n     = c.neg_q ? (~low + 1'b1) : low;
        q_n       = c.neg_q ? (~c.opy + 1'b1) : c.opy;
        r_n       = c.neg_r ? (~low + 1'b1) : low;
        upper     = |c.acc[2*W-1:W];
        exact_min = (low == {1'b1, {(W-1){1'b0}}});
        res       = '0;
        st        = ST_OK;
        if (c.is_mul)
        begin
            res = low_n;
            if (c.kind == K_SMUL_TRAP)
            begin
                if (upper || (low[W-1] && !(c.neg_q && exact_min)))
                begin
                    st = ST_OVF;
                end
            end
            else if (c.kind == K_UMUL_TRAP)
            begin
                if (upper)
                begin
                    st = ST_OVF;
                end
            end
        end
        else if (c.is_div)
        begin
            if (c.dz)
            begin
                st = ST_DZ;
            end
            else if (c.ovf)
            begin
                st = ST_OVF;
            end
            else if (c.kind >= K_SMOD_WRAP)
            begin
                res = r_n;
            end
            else
            begin
                res = q_n;
            end
        end
        if (st != ST_OK)
        begin
            res = '0;
        end
    end

endmodule

@@ hdl/wide_int_mul_div_trap_unit_top.sv @@
// Path from input transfer to result valid: the operand stage register, the
// 128 cell registers and the output register, in that order.
// Throughput: one operation per cycle unless the output stalls; all 128 cells
// advance together; a stalled result holds the whole row until it is taken.
// Reset: asynchronous, active low; clears all valid flags, no data is cleared.
// ----------------------------------------------------------------------------
// wide_int_mul_div_trap_unit_top: 128-bit multiply / divide unit with traps
// Operand preparation, a row of shift-add / restoring cells and result fix-up.
// ----------------------------------------------------------------------------
module wide_int_mul_div_trap_unit_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  kind,
    input  logic [63:0] a_low,
    input  logic [63:0] a_high,
    input  logic [63:0] b_low,
    input  logic [63:0] b_high,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_low,
    output logic [63:0] result_high,
    output logic [1:0]  status
);
    import wim_pkg::*;

    logic          en;
    cell_t         prep_next;
    cell_t         prep_reg;
    logic          prep_valid_reg;
    cell_t         chain [0:W];
    logic [W-1:0]  a;
    logic [W-1:0]  b;
    logic [W-1:0]  ma;
    logic [W-1:0]  mb;
    logic          sa;
    logic          sb;
    logic          sgn;
    logic          is_mul;
    logic          is_div;
    logic [127:0]  post_res;
    logic [1:0]    post_st;
    logic          out_valid_reg;
    logic [127:0]  res_reg;
    logic [1:0]    st_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        a      = {a_high, a_low};
        b      = {b_high, b_low};
        sa     = a_high[63];
        sb     = b_high[63];
        is_mul = (kind <= K_UMUL_TRAP);
        is_div = (kind >= K_SDIV_WRAP) && (kind <= K_UMOD);
        sgn    = (kind == K_SMUL_WRAP) || (kind == K_SMUL_TRAP) ||
                 (kind == K_SDIV_WRAP) || (kind == K_SDIV_TRAP) ||
                 (kind == K_SMOD_WRAP) || (kind == K_SMOD_TRAP);
        ma     = (sgn && sa) ? (~a + 1'b1) : a;
        mb     = (sgn && sb) ? (~b + 1'b1) : b;
        prep_next        = '0;
        prep_next.valid  = in_valid;
        prep_next.kind   = kind;
        prep_next.is_mul = is_mul;
        prep_next.is_div = is_div;
        prep_next.neg_q  = sgn && (sa ^ sb);
        prep_next.neg_r  = sgn && sa;
        prep_next.dz     = (b == '0);
        prep_next.ovf    = ((kind == K_SDIV_TRAP) || (kind == K_SMOD_TRAP)) &&
                           (a == {1'b1, {(W-1){1'b0}}}) && (b == '1);
        if (is_mul)
        begin
            prep_next.opx = {{W{1'b0}}, ma};
            prep_next.opy = mb;
        end
        else
        begin
            prep_next.acc = {ma, {W{1'b0}}};
            prep_next.opx = {{W{1'b0}}, mb};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
        end
    end

    always_comb
    begin
        chain[0]       = prep_reg;
        chain[0].valid = prep_valid_reg;
    end

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        wim_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d_in  (chain[i]),
            .d_out (chain[i+1])
        );
    end

    wim_post u_post (
        .c   (chain[W]),
        .res (post_res),
        .st  (post_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain[W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= post_res;
            st_reg  <= post_st;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_low  = res_reg[63:0];
    assign result_high = res_reg[127:64];
    assign status      = st_reg;

endmodule

@@ hdl/wim_checker.sv @@
// ----------------------------------------------------------------------------
// wim_checker: port-level checks of the multiply / divide unit
// Watches the handshakes and result encoding seen at the top-level ports.
// ----------------------------------------------------------------------------
module wim_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] result_low,
    input logic [63:0] result_high,
    input logic [1:0]  status
);
    import wim_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_low)
        && $stable(result_high) && $stable(status))
        else $error("Stalled result changed before transfer.");

    a_trap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (result_low == '0) && (result_high == '0))
        else $error("Trapped result is not zero.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_DZ) || (status == ST_OVF))
        else $error("Unknown status code.");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("Input ready does not follow output stall.");

endmodule

bind wide_int_mul_div_trap_unit_top wim_checker u_wim_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_low  (result_low),
    .result_high (result_high),
    .status      (status)
);
